// ===== rtl/core/lkv_pkg.sv =====
// Shared constants and types for the LRU key-value cache.
package lkv_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int KEY_W         = 32;
   localparam int VALUE_W       = 32;
   localparam int CAP_W         = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
   localparam logic [VALUE_W-1:0] MISS_VALUE = '1;
   localparam logic [VALUE_W-1:0] PUT_VALUE  = '0;

   typedef enum logic [0:0] {
      ACT_GET = 1'b0,
      ACT_PUT = 1'b1
   } action_type;

   typedef enum logic [0:0] {
      ST_IDLE   = 1'b0,
      ST_UPDATE = 1'b1
   } state_type;

   // per-cell update control
   typedef struct packed {
      logic take;   // load contents of the previous cell
      logic trim;   // drop the entry if it ends up last valid
   } cell_ctl_type;

endpackage

// ===== rtl/core/lkv_cell.sv =====
// One entry of the recency-ordered chain: key, value, valid and match flag.
module lkv_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          capture,
   input  logic [lkv_pkg::KEY_W-1:0]     req_key,
   input  lkv_pkg::cell_ctl_type         ctl,
   input  logic [lkv_pkg::KEY_W-1:0]     prev_key,
   input  logic [lkv_pkg::VALUE_W-1:0]   prev_value,
   input  logic                          prev_valid,
   input  logic                          next_valid_pre,
   output logic [lkv_pkg::KEY_W-1:0]     key,
   output logic [lkv_pkg::VALUE_W-1:0]   value,
   output logic                          valid,
   output logic                          match,
   output logic                          valid_pre
);

   logic [lkv_pkg::KEY_W-1:0]   key_ff;
   logic [lkv_pkg::KEY_W-1:0]   key_in;
   logic [lkv_pkg::VALUE_W-1:0] value_ff;
   logic [lkv_pkg::VALUE_W-1:0] value_in;
   logic                        valid_ff;
   logic                        valid_in;
   logic                        match_ff;
   logic                        match_in;

   always_comb begin
      key_in    = ctl.take ? prev_key   : key_ff;
      value_in  = ctl.take ? prev_value : value_ff;
      valid_pre = ctl.take ? prev_valid : valid_ff;
      // the last valid cell after the move is the least recent one
      valid_in  = valid_pre && !(ctl.trim && !next_valid_pre);
      match_in  = capture ? (valid_ff && (key_ff == req_key)) : match_ff;
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
   end

   assign key   = key_ff;
   assign value = value_ff;
   assign valid = valid_ff;
   assign match = match_ff;

endmodule

// ===== rtl/core/lru_key_value_cache_top.sv =====
// Top level of the LRU key-value cache: request control, cell chain and result register.
//
// A fully associative key-value store kept as a chain of DEPTH cells ordered
// from most recent (cell 0) to least recent. For each request, at the
// accepting edge every cell compares its key with the request key; in the
// next cycle the hit entry or, on a put miss, the new key moves to cell 0,
// the cells in front of it step down one place, a put drops a least recent
// entry when the count exceeds the capacity, and the result beat is registered.
// A new request is taken only while idle and when the result register is free or being
// drained in that cycle. The store is empty after reset; no clearing pass is needed.
module lru_key_value_cache_top #(
   parameter int DEPTH = lkv_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wen,
   input  logic [lkv_pkg::CAP_W-1:0]     csr_wdata,    // capacity
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [63:0]                   req_tdata,    // key[31:0], value[63:32]
   input  logic                          req_tuser,    // action
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [31:0]                   rsp_tdata,    // read_value[31:0]
   output logic                          rsp_tuser     // hit
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > lkv_pkg::CAP_W) ? CNT_W : lkv_pkg::CAP_W;

   lkv_pkg::state_type              state_ff, state_in;
   logic [lkv_pkg::CAP_W-1:0]       capacity_ff;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic                            action_ff;
   logic [lkv_pkg::KEY_W-1:0]       key_ff;
   logic [lkv_pkg::VALUE_W-1:0]     value_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_hit_ff;
   logic [lkv_pkg::VALUE_W-1:0]     rsp_value_ff;

   logic                            accept;
   logic                            update;
   logic                            any_hit;
   logic                            put_miss;
   logic                            trim;
   logic [lkv_pkg::VALUE_W-1:0]     hit_value;
   logic [CNT_W-1:0]                count_new;
   logic [CMP_W-1:0]                cap_eff;

   logic [lkv_pkg::KEY_W-1:0]       cell_key   [DEPTH];
   logic [lkv_pkg::VALUE_W-1:0]     cell_value [DEPTH];
   logic [DEPTH-1:0]                cell_valid;
   logic [DEPTH-1:0]                cell_match;
   logic [DEPTH-1:0]                cell_valid_pre;
   logic [DEPTH-1:0]                seen;
   lkv_pkg::cell_ctl_type           cell_ctl [DEPTH];

   assign req_tready = (state_ff == lkv_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign update     = (state_ff == lkv_pkg::ST_UPDATE);

   always_comb begin
      unique case (state_ff)
         lkv_pkg::ST_IDLE:   state_in = accept ? lkv_pkg::ST_UPDATE : lkv_pkg::ST_IDLE;
         lkv_pkg::ST_UPDATE: state_in = lkv_pkg::ST_IDLE;
         default:            state_in = lkv_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lkv_pkg::ST_IDLE;
         capacity_ff  <= lkv_pkg::CAP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            capacity_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_tuser;
         key_ff    <= req_tdata[31:0];
         value_ff  <= req_tdata[63:32];
      end
      if (update) begin
         rsp_hit_ff <= any_hit;
         if (action_ff == lkv_pkg::ACT_PUT) begin
            rsp_value_ff <= lkv_pkg::PUT_VALUE;
         end else if (any_hit) begin
            rsp_value_ff <= hit_value;
         end else begin
            rsp_value_ff <= lkv_pkg::MISS_VALUE;
         end
      end
   end

   // one-hot select of the matching entry
   always_comb begin
      hit_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         hit_value = hit_value | (cell_value[i] & {lkv_pkg::VALUE_W{cell_match[i]}});
      end
   end

   assign any_hit  = |cell_match;
   assign put_miss = (action_ff == lkv_pkg::ACT_PUT) && !any_hit;
   assign cap_eff  = (CMP_W'(capacity_ff) > CMP_W'(DEPTH))
                     ? CMP_W'(DEPTH)
                     : CMP_W'(capacity_ff);

   always_comb begin
      count_new = count_ff;
      if (put_miss && (count_ff != CNT_W'(DEPTH))) begin
         count_new = count_ff + CNT_W'(1);
      end
      trim = update && (action_ff == lkv_pkg::ACT_PUT)
             && (CMP_W'(count_new) > cap_eff);
      count_in = count_ff;
      if (update) begin
         count_in = trim ? (count_new - CNT_W'(1)) : count_new;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (update) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_hit_ff;

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         logic [lkv_pkg::KEY_W-1:0]   prev_key;
         logic [lkv_pkg::VALUE_W-1:0] prev_value;
         logic                        prev_valid;
         logic                        next_valid_pre;

         if (g == 0) begin : g_front
            assign seen[g]    = 1'b0;
            assign prev_key   = key_ff;
            assign prev_value = (action_ff == lkv_pkg::ACT_PUT) ? value_ff : hit_value;
            assign prev_valid = 1'b1;
         end else begin : g_link
            assign seen[g]    = |cell_match[g-1:0];
            assign prev_key   = cell_key[g-1];
            assign prev_value = cell_value[g-1];
            assign prev_valid = cell_valid[g-1];
         end

         if (g == DEPTH - 1) begin : g_tail
            assign next_valid_pre = 1'b0;
         end else begin : g_mid
            assign next_valid_pre = cell_valid_pre[g+1];
         end

         // cells up to the hit position step down; a put miss shifts all
         assign cell_ctl[g].take = update && (put_miss || (any_hit && !seen[g]));
         assign cell_ctl[g].trim = trim;

         lkv_cell u_cell (
            .clock          (clock),
            .reset          (reset),
            .capture        (accept),
            .req_key        (req_tdata[31:0]),
            .ctl            (cell_ctl[g]),
            .prev_key       (prev_key),
            .prev_value     (prev_value),
            .prev_valid     (prev_valid),
            .next_valid_pre (next_valid_pre),
            .key            (cell_key[g]),
            .value          (cell_value[g]),
            .valid          (cell_valid[g]),
            .match          (cell_match[g]),
            .valid_pre      (cell_valid_pre[g])
         );
      end
   endgenerate

endmodule
